// ===== sv/cbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types, register codes and colour tables of the color bar generator.
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int COORD_BITS = 12;
  localparam int ADDR_BITS  = 28;
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = 3;
  localparam int DEPTH_BITS = 6;
  localparam int STRIDE_BITS = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;
  localparam int BAR_COUNT = 8;
  localparam int BAND_BITS = COORD_BITS - 3;
  localparam int PROD_BITS = COORD_BITS + 1 + STRIDE_BITS;
  localparam int XB_BITS   = COORD_BITS + 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_XOFF   = 3'd2,
    REG_YOFF   = 3'd3,
    REG_DEPTH  = 3'd4,
    REG_STRIDE = 3'd5
  } reg_idx_e;

  localparam logic [DEPTH_BITS-1:0] BPP_16 = 6'd16;
  localparam logic [DEPTH_BITS-1:0] BPP_24 = 6'd24;
  localparam logic [DEPTH_BITS-1:0] BPP_32 = 6'd32;

  localparam logic [CNT_BITS-1:0] BYTES_16  = 3'd2;
  localparam logic [CNT_BITS-1:0] BYTES_24  = 3'd3;
  localparam logic [CNT_BITS-1:0] BYTES_32  = 3'd4;
  localparam logic [CNT_BITS-1:0] BYTES_BAD = 3'd0;

  localparam logic [23:0] RGB_RED   = 24'hFF0000;
  localparam logic [23:0] RGB_BLACK = 24'h000000;
  localparam logic [7:0]  ALPHA     = 8'hFF;

  typedef enum logic [1:0] {
    DEP_32,
    DEP_24,
    DEP_16,
    DEP_BAD
  } depth_e;

  typedef enum logic [1:0] {
    CLS_RED,
    CLS_BLACK,
    CLS_BAR
  } ring_e;

  typedef struct packed {
    logic [COORD_BITS-1:0]  width;
    logic [COORD_BITS-1:0]  height;
    logic [COORD_BITS-1:0]  x_off;
    logic [COORD_BITS-1:0]  y_off;
    logic [DEPTH_BITS-1:0]  depth;
    logic [STRIDE_BITS-1:0] stride;
  } cfg_t;

  // stage 1: registered request
  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  rev;
  } s1_t;

  // stage 2: panned coordinates, ring class, bar threshold compares
  typedef struct packed {
    logic                   valid;
    logic [COORD_BITS:0]    xs;
    logic [COORD_BITS:0]    ys;
    ring_e                  cls;
    logic [BAR_COUNT-1:0]   ge;
    logic                   rev;
  } s2_t;

  // stage 3: row product, column bytes, chosen colour
  typedef struct packed {
    logic                 valid;
    logic [PROD_BITS-1:0] prod;
    logic [XB_BITS-1:0]   xb;
    logic [23:0]          rgb;
    depth_e               dep;
  } s3_t;

  function automatic logic [23:0] bar_rgb(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = 24'h000000;
      3'd1:    c = 24'hFF0000;
      3'd2:    c = 24'hFF00FF;
      3'd3:    c = 24'hFFFF00;
      3'd4:    c = 24'h00FF00;
      3'd5:    c = 24'h00FFFF;
      3'd6:    c = 24'h0000FF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  // every channel used here is 00 or FF, so scaling to 5/6 bits is a replication
  function automatic logic [15:0] rgb565(input logic [23:0] c);
    return {{5{c[23]}}, {6{c[15]}}, {5{c[7]}}};
  endfunction

endpackage
`default_nettype wire

// ===== sv/cbp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbp interfaces
// Pixel request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface cbp_pix_if;
  logic                          valid;
  logic                          ready;
  logic [cbp_pkg::COORD_BITS-1:0] pos_x;
  logic [cbp_pkg::COORD_BITS-1:0] pos_y;
  modport source (output valid, pos_x, pos_y, input ready);
  modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

interface cbp_res_if;
  logic                          valid;
  logic                          ready;
  logic [cbp_pkg::ADDR_BITS-1:0] byte_address;
  logic [cbp_pkg::WORD_BITS-1:0] pixel_word;
  logic [cbp_pkg::CNT_BITS-1:0]  byte_count;
  logic                          depth_error;
  modport source (output valid, byte_address, pixel_word, byte_count, depth_error,
                  input ready);
  modport sink   (input valid, byte_address, pixel_word, byte_count, depth_error,
                  output ready);
endinterface

interface cbp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbp_pkg::CFG_IDX_BITS-1:0]  index;
  logic [cbp_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/cbp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_front
// Request register, frame flag, ring classification and bar threshold compares.
// ----------------------------------------------------------------------------
module cbp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cbp_pkg::cfg_t      cfg_i,
  cbp_pix_if.sink            pix_i,
  output cbp_pkg::s2_t       s2_o,
  input  wire logic          s2_ready_i
);

  cbp_pkg::s1_t s1_q, s1_d;
  cbp_pkg::s2_t s2_q, s2_d;
  logic         rev_q, rev_d;
  logic         s1_ready, accept, first_pix;

  logic [cbp_pkg::COORD_BITS:0]    x1, y1, x4, y4, w, h;
  logic [cbp_pkg::BAND_BITS-1:0]   band;
  logic [cbp_pkg::COORD_BITS-1:0]  thr [cbp_pkg::BAR_COUNT];
  logic                            red, black;

  assign s1_ready    = !s2_q.valid || s2_ready_i;
  assign pix_i.ready = !s1_q.valid || s1_ready;
  assign accept      = pix_i.valid && pix_i.ready;
  assign first_pix   = (pix_i.pos_x == '0) && (pix_i.pos_y == '0);

  // flag flips before the first pixel's colour is chosen
  always_comb begin
    rev_d = rev_q;
    s1_d  = s1_q;
    if (accept) begin
      rev_d      = rev_q ^ first_pix;
      s1_d.valid = 1'b1;
      s1_d.x     = pix_i.pos_x;
      s1_d.y     = pix_i.pos_y;
      s1_d.rev   = rev_q ^ first_pix;
    end else if (s1_ready) begin
      s1_d.valid = 1'b0;
    end
  end

  always_comb begin
    x1   = {1'b0, s1_q.x} + 1'b1;
    y1   = {1'b0, s1_q.y} + 1'b1;
    x4   = {1'b0, s1_q.x} + 3'd4;
    y4   = {1'b0, s1_q.y} + 3'd4;
    w    = {1'b0, cfg_i.width};
    h    = {1'b0, cfg_i.height};
    band = cfg_i.height[cbp_pkg::COORD_BITS-1:3];
    red   = (s1_q.x == '0) || (x1 >= w) || (s1_q.y == '0) || (y1 >= h);
    black = (s1_q.x <= 3) || (x4 >= w) || (s1_q.y <= 3) || (y4 >= h);
    for (int k = 0; k < cbp_pkg::BAR_COUNT; k++) begin
      thr[k] = cbp_pkg::COORD_BITS'(band * (k + 1));
    end
  end

  always_comb begin
    s2_d = s2_q;
    if (s1_ready) begin
      s2_d.valid = s1_q.valid;
      s2_d.xs    = {1'b0, s1_q.x} + {1'b0, cfg_i.x_off};
      s2_d.ys    = {1'b0, s1_q.y} + {1'b0, cfg_i.y_off};
      s2_d.rev   = s1_q.rev;
      if (red) begin
        s2_d.cls = cbp_pkg::CLS_RED;
      end else if (black) begin
        s2_d.cls = cbp_pkg::CLS_BLACK;
      end else begin
        s2_d.cls = cbp_pkg::CLS_BAR;
      end
      // thermometer: ge[k] set when the row lies at or below bar k+1's top
      for (int k = 0; k < cbp_pkg::BAR_COUNT; k++) begin
        s2_d.ge[k] = s1_q.y >= thr[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q <= 1'b0;
      s1_q  <= '0;
      s2_q  <= '0;
    end else begin
      rev_q <= rev_d;
      s1_q  <= s1_d;
      s2_q  <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule
`default_nettype wire

// ===== sv/cbp_mid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_mid
// Row address product, column byte offset, bar index and colour selection.
// ----------------------------------------------------------------------------
module cbp_mid (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cbp_pkg::cfg_t      cfg_i,
  input  cbp_pkg::s2_t       s2_i,
  output logic               s2_ready_o,
  output cbp_pkg::s3_t       s3_o,
  input  wire logic          s3_ready_i
);

  cbp_pkg::s3_t s3_q, s3_d;
  cbp_pkg::depth_e dep;
  logic [2:0]      idx;

  assign s2_ready_o = !s3_q.valid || s3_ready_i;

  always_comb begin
    case (cfg_i.depth)
      cbp_pkg::BPP_32: dep = cbp_pkg::DEP_32;
      cbp_pkg::BPP_24: dep = cbp_pkg::DEP_24;
      cbp_pkg::BPP_16: dep = cbp_pkg::DEP_16;
      default:         dep = cbp_pkg::DEP_BAD;
    endcase
  end

  always_comb begin
    idx = 3'($countones(s2_i.ge[cbp_pkg::BAR_COUNT-2:0]));
    if (s2_i.rev) begin
      idx = ~idx;
    end
  end

  always_comb begin
    s3_d = s3_q;
    if (s2_ready_o) begin
      s3_d.valid = s2_i.valid;
      s3_d.dep   = dep;
      s3_d.prod  = cbp_pkg::PROD_BITS'(s2_i.ys) * cbp_pkg::PROD_BITS'(cfg_i.stride);
      case (dep)
        cbp_pkg::DEP_32: s3_d.xb = {s2_i.xs, 2'b00};
        cbp_pkg::DEP_24: s3_d.xb = {1'b0, s2_i.xs, 1'b0} + {2'b00, s2_i.xs};
        cbp_pkg::DEP_16: s3_d.xb = {1'b0, s2_i.xs, 1'b0};
        default:         s3_d.xb = '0;
      endcase
      case (s2_i.cls)
        cbp_pkg::CLS_RED:   s3_d.rgb = cbp_pkg::RGB_RED;
        cbp_pkg::CLS_BLACK: s3_d.rgb = cbp_pkg::RGB_BLACK;
        default: begin
          // past the last full bar, or bar height zero: black
          if (s2_i.ge[cbp_pkg::BAR_COUNT-1]) begin
            s3_d.rgb = cbp_pkg::RGB_BLACK;
          end else begin
            s3_d.rgb = cbp_pkg::bar_rgb(idx);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule
`default_nettype wire

// ===== sv/cbp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_back
// Final address sum, pixel packing per depth and the output register.
// ----------------------------------------------------------------------------
module cbp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cbp_pkg::s3_t       s3_i,
  output logic               s3_ready_o,
  cbp_res_if.source          res_o
);

  logic                          valid_q, valid_d;
  logic [cbp_pkg::ADDR_BITS-1:0] addr_q, addr_d;
  logic [cbp_pkg::WORD_BITS-1:0] word_q, word_d;
  logic [cbp_pkg::CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                          err_q, err_d;
  logic [cbp_pkg::ADDR_BITS-1:0] sum;

  assign s3_ready_o = !valid_q || res_o.ready;
  assign sum = cbp_pkg::ADDR_BITS'(s3_i.prod) + cbp_pkg::ADDR_BITS'(s3_i.xb);

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    word_d  = word_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    if (s3_ready_o) begin
      valid_d = s3_i.valid;
      addr_d  = sum;
      err_d   = 1'b0;
      case (s3_i.dep)
        cbp_pkg::DEP_32: begin
          word_d = {cbp_pkg::ALPHA, s3_i.rgb};
          cnt_d  = cbp_pkg::BYTES_32;
        end
        cbp_pkg::DEP_24: begin
          word_d = {8'h00, s3_i.rgb};
          cnt_d  = cbp_pkg::BYTES_24;
        end
        cbp_pkg::DEP_16: begin
          word_d = {16'h0000, cbp_pkg::rgb565(s3_i.rgb)};
          cnt_d  = cbp_pkg::BYTES_16;
        end
        default: begin
          word_d = '0;
          addr_d = '0;
          cnt_d  = cbp_pkg::BYTES_BAD;
          err_d  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    word_q <= word_d;
    cnt_q  <= cnt_d;
    err_q  <= err_d;
  end

  assign res_o.valid        = valid_q;
  assign res_o.byte_address = addr_q;
  assign res_o.pixel_word   = word_q;
  assign res_o.byte_count   = cnt_q;
  assign res_o.depth_error  = err_q;

endmodule
`default_nettype wire

// ===== sv/color_bar_pattern_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// color_bar_pattern_generator_unit
// Eight color bar test pattern: pixel coordinate in, framebuffer address and
// packed pixel out.
// ----------------------------------------------------------------------------
// Channels: pix_i takes one request (pos_x, pos_y) per valid/ready handshake;
// res_o returns byte_address, pixel_word, byte_count and depth_error, one result
// per request, in order. cfg_i writes the six registers (index 0..5: width,
// height, x offset, y offset, depth, stride) and is always ready; other indexes
// are ignored. The user writes only while no request is in flight (unchecked).
// Path: request register, then the classify, multiply/select and pack registers.
// Throughput: one pixel per clock unless the receiver stalls; the 13x14 row
// multiply shares its stage with the column byte offset and colour select.
// Stalls: each stage holds while the next is full, so bubbles close up and
// pix_i stays ready until all four stages hold results behind a stalled
// receiver. Nothing is dropped or repeated.
// Reset: registers return to 800x480, no pan, 32 bpp, stride 3200; the bar
// order flag clears and flips at every pixel (0,0), so the first frame is
// drawn bottom up.
// ----------------------------------------------------------------------------
module color_bar_pattern_generator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cbp_cfg_if.sink   cfg_i,
  cbp_pix_if.sink   pix_i,
  cbp_res_if.source res_o
);

  cbp_pkg::cfg_t cfg_q, cfg_d;
  cbp_pkg::s2_t  s2;
  cbp_pkg::s3_t  s3;
  logic          s2_ready, s3_ready;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        cbp_pkg::REG_WIDTH:  cfg_d.width  = cfg_i.data[cbp_pkg::COORD_BITS-1:0];
        cbp_pkg::REG_HEIGHT: cfg_d.height = cfg_i.data[cbp_pkg::COORD_BITS-1:0];
        cbp_pkg::REG_XOFF:   cfg_d.x_off  = cfg_i.data[cbp_pkg::COORD_BITS-1:0];
        cbp_pkg::REG_YOFF:   cfg_d.y_off  = cfg_i.data[cbp_pkg::COORD_BITS-1:0];
        cbp_pkg::REG_DEPTH:  cfg_d.depth  = cfg_i.data[cbp_pkg::DEPTH_BITS-1:0];
        cbp_pkg::REG_STRIDE: cfg_d.stride = cfg_i.data[cbp_pkg::STRIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 12'd800;
      cfg_q.height <= 12'd480;
      cfg_q.x_off  <= '0;
      cfg_q.y_off  <= '0;
      cfg_q.depth  <= cbp_pkg::BPP_32;
      cfg_q.stride <= 14'd3200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_i      (pix_i),
    .s2_o       (s2),
    .s2_ready_i (s2_ready)
  );

  cbp_mid u_mid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s2_i       (s2),
    .s2_ready_o (s2_ready),
    .s3_o       (s3),
    .s3_ready_i (s3_ready)
  );

  cbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s3_i       (s3),
    .s3_ready_o (s3_ready),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

// ===== tb/color_bar_pattern_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_bar_pattern_generator_unit_tb
// Drives pixel requests and register writes into the color bar generator,
// predicts address, packed pixel, byte count and depth flag for each request,
// and checks every result in order under random sender and receiver stalls.
// ----------------------------------------------------------------------------
module color_bar_pattern_generator_unit_tb;
  import cbp_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 750;
  localparam int SEGMENTS     = 8;

  // indexes outside the register map, ignored by the block
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  // bar membership of each channel, bar 0 at the top
  localparam logic [7:0] RED_BARS   = 8'b1000_1110;
  localparam logic [7:0] GREEN_BARS = 8'b1011_1000;
  localparam logic [7:0] BLUE_BARS  = 8'b1110_0100;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] word;
    logic [CNT_BITS-1:0]  count;
    logic                 err;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbp_cfg_if cfg ();
  cbp_pix_if pix ();
  cbp_res_if res ();

  color_bar_pattern_generator_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .pix_i (pix),
    .res_o (res)
  );

  // register shadow and bar order flag
  logic [COORD_BITS-1:0]  cfg_width  = 12'd800;
  logic [COORD_BITS-1:0]  cfg_height = 12'd480;
  logic [COORD_BITS-1:0]  cfg_xoff   = 12'd0;
  logic [COORD_BITS-1:0]  cfg_yoff   = 12'd0;
  logic [DEPTH_BITS-1:0]  cfg_depth  = BPP_32;
  logic [STRIDE_BITS-1:0] cfg_stride = 14'd3200;
  logic                   bars_reversed = 1'b0;

  pixel_result_t pending_pixels[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("color_bar_pattern_generator_unit_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic pixel_result_t predict_pixel(input logic [COORD_BITS-1:0] x,
                                                  input logic [COORD_BITS-1:0] y);
    int unsigned   xi, yi, w, h, band, idx, r, g, b, bytes;
    logic [23:0]   rgb;
    pixel_result_t p;
    xi = x;
    yi = y;
    w  = cfg_width;
    h  = cfg_height;
    if (x == '0 && y == '0) bars_reversed = !bars_reversed;
    // ring tests are done as x + 1 >= width so a width of 0 or 1 is all red
    if (xi == 0 || xi + 1 >= w || yi == 0 || yi + 1 >= h) begin
      rgb = RGB_RED;
    end else if (xi <= 3 || xi + 4 >= w || yi <= 3 || yi + 4 >= h) begin
      rgb = RGB_BLACK;
    end else begin
      band = h / 8;
      idx  = (band == 0) ? 8 : yi / band;
      if (idx > 7) begin
        rgb = RGB_BLACK;
      end else begin
        if (bars_reversed) idx = 7 - idx;
        rgb = {{8{RED_BARS[idx]}}, {8{GREEN_BARS[idx]}}, {8{BLUE_BARS[idx]}}};
      end
    end
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    case (cfg_depth)
      BPP_32: begin
        p.count = BYTES_32;
        p.word  = {ALPHA, rgb};
      end
      BPP_24: begin
        p.count = BYTES_24;
        p.word  = {8'h00, rgb};
      end
      BPP_16: begin
        p.count = BYTES_16;
        p.word  = (((r * 31) / 255) << 11) | (((g * 63) / 255) << 5) | ((b * 31) / 255);
      end
      default: begin
        p.count = BYTES_BAD;
        p.word  = '0;
      end
    endcase
    bytes = p.count;
    if (p.count == BYTES_BAD) p.addr = '0;
    else p.addr = ADDR_BITS'((xi + cfg_xoff) * bytes + (yi + cfg_yoff) * cfg_stride);
    p.err = (p.count == BYTES_BAD);
    return p;
  endfunction

  // result checker: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst_n && res.valid && res.ready) begin
      got.addr  = res.byte_address;
      got.word  = res.pixel_word;
      got.count = res.byte_count;
      got.err   = res.depth_error;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result addr=%h word=%h bytes=%0d err=%b", $time,
                 got.addr, got.word, got.count, got.err);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected addr=%h word=%h bytes=%0d err=%b", $time,
                   want.addr, want.word, want.count, want.err);
          $display("%0t:          actual   addr=%h word=%h bytes=%0d err=%b", $time,
                   got.addr, got.word, got.count, got.err);
          fail_count++;
        end
      end
    end
  end

  // valid is left high on return so back-to-back requests keep valid asserted between them
  task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pos_x <= x;
    pix.pos_y <= y;
    do @(posedge clk); while (!pix.ready);
    pending_pixels.push_back(predict_pixel(x, y));
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_WIDTH:  cfg_width  = val[COORD_BITS-1:0];
      REG_HEIGHT: cfg_height = val[COORD_BITS-1:0];
      REG_XOFF:   cfg_xoff   = val[COORD_BITS-1:0];
      REG_YOFF:   cfg_yoff   = val[COORD_BITS-1:0];
      REG_DEPTH:  cfg_depth  = val[DEPTH_BITS-1:0];
      REG_STRIDE: cfg_stride = val[STRIDE_BITS-1:0];
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_dimension();
    case ($urandom_range(9))
      0:       return 14'd1;
      1:       return 14'd4095;
      2, 3, 4: return CFG_DATA_BITS'($urandom_range(40, 1));
      5:       return CFG_DATA_BITS'($urandom_range(16383));
      default: return CFG_DATA_BITS'($urandom_range(4095, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_offset();
    case ($urandom_range(5))
      0:       return 14'd0;
      1:       return 14'd4095;
      2:       return CFG_DATA_BITS'($urandom_range(16383));
      default: return CFG_DATA_BITS'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_depth();
    case ($urandom_range(9))
      0:       return CFG_DATA_BITS'($urandom_range(63));
      1:       return CFG_DATA_BITS'($urandom_range(16383));
      2, 3, 4: return CFG_DATA_BITS'(BPP_16);
      5, 6:    return CFG_DATA_BITS'(BPP_24);
      default: return CFG_DATA_BITS'(BPP_32);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_stride();
    case ($urandom_range(5))
      0:       return 14'd1;
      1:       return 14'd16383;
      default: return CFG_DATA_BITS'($urandom_range(16383));
    endcase
  endfunction

  task automatic randomize_config();
    write_reg(REG_WIDTH, pick_dimension());
    write_reg(REG_HEIGHT, pick_dimension());
    write_reg(REG_XOFF, pick_offset());
    write_reg(REG_YOFF, pick_offset());
    write_reg(REG_DEPTH, pick_depth());
    write_reg(REG_STRIDE, pick_stride());
  endtask

  // mostly inside or just around the frame so rings and bars are hit
  task automatic random_pixel();
    int unsigned xl, yl, sel;
    xl  = (cfg_width  >= 12'd4095) ? 4095 : cfg_width + 1;
    yl  = (cfg_height >= 12'd4095) ? 4095 : cfg_height + 1;
    sel = $urandom_range(9);
    if (sel == 0)
      send_pixel('0, '0);
    else if (sel <= 6)
      send_pixel(COORD_BITS'($urandom_range(xl)), COORD_BITS'($urandom_range(yl)));
    else
      send_pixel(COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)));
  endtask

  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0);          // first frame flips to reversed order
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4, 12'd4);
    send_pixel(12'd799, 12'd240);
    for (int k = 0; k < BAR_COUNT; k++) send_pixel(12'd400, COORD_BITS'(60 * k + 10));
    send_pixel(12'd0, 12'd0);          // back to top-down order
    send_pixel(12'd400, 12'd70);
  endtask

  task automatic test_depths();
    wait_idle();
    write_reg(REG_XOFF, 14'd4095);
    write_reg(REG_YOFF, 14'd4095);
    write_reg(REG_STRIDE, 14'd16383);
    send_pixel(12'd4095, 12'd4095);    // largest pan and stride; the address still fits in 28 bits
    wait_idle();
    write_reg(REG_DEPTH, CFG_DATA_BITS'(BPP_16));
    send_pixel(12'd400, 12'd130);
    wait_idle();
    write_reg(REG_DEPTH, CFG_DATA_BITS'(BPP_24));
    send_pixel(12'd400, 12'd190);
    wait_idle();
    write_reg(REG_DEPTH, 14'd0);
    send_pixel(12'd400, 12'd250);
    send_pixel(12'd0, 12'd0);          // flag still flips with a bad depth
    wait_idle();
    write_reg(REG_DEPTH, 14'd63);
    send_pixel(12'd400, 12'd310);
  endtask

  task automatic test_geometry();
    wait_idle();
    write_reg(REG_DEPTH, CFG_DATA_BITS'(BPP_32));
    write_reg(REG_XOFF, 14'd0);
    write_reg(REG_YOFF, 14'd0);
    write_reg(REG_STRIDE, 14'd1);
    write_reg(REG_WIDTH, 14'h1000);    // masks to width 0
    write_reg(REG_HEIGHT, 14'd1);
    send_pixel(12'd8, 12'd8);
    wait_idle();
    write_reg(REG_WIDTH, 14'd20);
    write_reg(REG_HEIGHT, 14'd13);     // bar height 1, row 8 is past the last bar
    write_reg(REG_SPARE_6, 14'h3fff);
    write_reg(REG_SPARE_7, 14'h3fff);
    send_pixel(12'd6, 12'd8);
    wait_idle();
    write_reg(REG_HEIGHT, 14'd7);      // bar height 0
    send_pixel(12'd6, 12'd3);
    wait_idle();
    write_reg(REG_WIDTH, 14'd4095);
    write_reg(REG_HEIGHT, 14'd4095);
    send_pixel(12'd100, 12'd4087);
  endtask

  task automatic test_random_traffic();
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    int unsigned per_seg;
    send_pct = '{0, 50, 0, 8};
    recv_pct = '{0, 0, 50, 8};
    per_seg  = RANDOM_ITEMS / SEGMENTS;
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < SEGMENTS / 4; s++) begin
        wait_idle();
        randomize_config();
        send_idle_pct  = send_pct[p];
        recv_stall_pct = recv_pct[p];
        for (int i = 0; i < per_seg; i++) begin
          // hold off once until the pipeline has fully drained
          if (p == 1 && s == 0 && i == per_seg / 2) wait_idle();
          random_pixel();
        end
      end
    end
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pos_x = '0;
    pix.pos_y = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    res.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_depths();
    test_geometry();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("color_bar_pattern_generator_unit_tb: PASS");
    end else begin
      $display("color_bar_pattern_generator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
